>>> sv/sysex_multi_mode_checksum_core_macros.svh
// ----------------------------------------------------------------------------
// SysEx checksum core assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SYSEX_MULTI_MODE_CHECKSUM_CORE_MACROS_SVH
`define SYSEX_MULTI_MODE_CHECKSUM_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define SMCC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smcc check failed");
`define SMCC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smcc check failed");
`else
`define SMCC_ASSERT_IMP(name, ante, cons)
`define SMCC_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> sv/smcc_pkg.sv
// ----------------------------------------------------------------------------
// smcc_pkg
// Shared widths, codes and beat types of the SysEx checksum core.
// ----------------------------------------------------------------------------
`default_nettype none

package smcc_pkg;

  localparam int CHAR_W     = 8;
  localparam int CK_W       = 7;
  localparam int ST_W       = 3;
  localparam int USED_W     = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - USED_W - ST_W - CK_W;

  localparam logic [2:0] MODE_TWOS    = 3'd0;
  localparam logic [2:0] MODE_XOR     = 3'd1;
  localparam logic [2:0] MODE_ONES    = 3'd2;
  localparam logic [2:0] MODE_SUM     = 3'd3;
  localparam logic [2:0] MODE_SUM_ALT = 3'd4;
  localparam logic [2:0] MODE_MAGIC   = 3'd5;

  localparam logic KIND_LENGTH = 1'b0;
  localparam logic KIND_OFFSET = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_HEX   = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_START = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_LEN   = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_OFS   = 3'd4;
  localparam logic [ST_W-1:0] ST_EXCEEDS   = 3'd5;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KIND  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_START = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE = 2'd3;

  localparam logic [15:0] MAGIC_BASE = 16'h5A3C;

  typedef struct packed {
    logic [2:0]       mode;
    logic             kind;
    logic [CFG_W-1:0] start;
    logic [CFG_W-1:0] range_val;
  } smcc_cfg_t;

  typedef struct packed {
    logic [CK_W-1:0] data;
    logic            byte_vld;
    logic            msg_err;
    logic            last;
  } smcc_beat_t;

  typedef struct packed {
    logic [CK_W-1:0] sum;
    logic [CK_W-1:0] xsum;
    logic            err;
  } smcc_snap_t;

endpackage

`default_nettype wire

>>> sv/smcc_hex_stage.sv
// ----------------------------------------------------------------------------
// smcc_hex_stage
// Skip whitespace, decode hex digits, flag bad or unpaired digits and pair nibbles into byte beats.
// ----------------------------------------------------------------------------
`default_nettype none

module smcc_hex_stage import smcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              in_last,
  input  logic              drain,
  output logic              beat_vld,
  output smcc_beat_t        beat
);

  logic [3:0] high_r, high_nxt;
  logic       pend_r, pend_nxt;
  logic       herr_r, herr_nxt;
  logic       vld_r, vld_nxt;
  smcc_beat_t beat_r, beat_nxt;
  logic       is_ws, is_dec, is_lc, is_uc;
  logic [3:0] digit;

  always_comb begin
    is_ws  = (in_char == 8'h20) || ((in_char >= 8'h09) && (in_char <= 8'h0D));
    is_dec = (in_char >= 8'h30) && (in_char <= 8'h39);
    is_lc  = (in_char >= 8'h61) && (in_char <= 8'h66);
    is_uc  = (in_char >= 8'h41) && (in_char <= 8'h46);
    digit  = is_dec ? in_char[3:0] : (in_char[3:0] + 4'd9);

    high_nxt = high_r;
    pend_nxt = pend_r;
    herr_nxt = herr_r;
    beat_nxt = beat_r;
    vld_nxt  = vld_r;
    if (drain) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt           = 1'b1;
      beat_nxt.byte_vld = 1'b0;
      beat_nxt.data     = {high_r[2:0], digit};
      beat_nxt.last     = in_last;
      if (!is_ws && !herr_r) begin
        if (!(is_dec || is_lc || is_uc)) begin
          herr_nxt = 1'b1;
        end else if (!pend_r) begin
          high_nxt = digit;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt          = 1'b0;
          beat_nxt.byte_vld = 1'b1;
        end
      end
      beat_nxt.msg_err = herr_nxt | pend_nxt;
      if (in_last) begin
        herr_nxt = 1'b0;
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
      herr_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      pend_r <= pend_nxt;
      herr_r <= herr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    high_r <= high_nxt;
    beat_r <= beat_nxt;
  end

  assign beat_vld = vld_r;
  assign beat     = beat_r;

endmodule

`default_nettype wire

>>> sv/smcc_tail_cell.sv
// ----------------------------------------------------------------------------
// smcc_tail_cell
// One byte slot of the tail delay line: shift from the neighbor or take new.
// ----------------------------------------------------------------------------
`default_nettype none

module smcc_tail_cell import smcc_pkg::*; (
  input  logic            clk,
  input  logic            shift,
  input  logic            load_new,
  input  logic [CK_W-1:0] din_new,
  input  logic [CK_W-1:0] din_next,
  output logic [CK_W-1:0] q
);

  logic [CK_W-1:0] q_r, q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (shift) begin
      q_nxt = load_new ? din_new : din_next;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

>>> sv/smcc_window_acc.sv
// ----------------------------------------------------------------------------
// smcc_window_acc
// Count bytes, test the window, run the tail delay line and accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

module smcc_window_acc import smcc_pkg::*; #(
  parameter int MAX_BYTES      = 65535,
  parameter int MAX_END_OFFSET = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  smcc_beat_t                         beat,
  input  smcc_cfg_t                          cfg,
  output logic [$clog2(MAX_BYTES+1)-1:0]     fin_count,
  output smcc_snap_t                         fin_snap
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int CMP_W = (CNT_W > CFG_W + 1) ? CNT_W : CFG_W + 1;
  localparam int DEPTH = MAX_END_OFFSET;

  logic [CNT_W-1:0] count_r, count_nxt, count_upd;
  logic             ovf_r, ovf_nxt, ovf_upd;
  logic [CK_W-1:0]  sum_r, sum_nxt, sum_upd;
  logic [CK_W-1:0]  xsum_r, xsum_nxt, xsum_upd;
  logic [CMP_W-1:0] idx_w, start_w, lim_w;
  logic             at_full, rv_big, accept, take_new, take_ring, ring_act;
  logic [CK_W-1:0]  take_val;
  logic [CFG_W-1:0] rv_m1;
  logic [CK_W-1:0]  cell_q [DEPTH];

  always_comb begin
    idx_w     = CMP_W'(count_r);
    start_w   = CMP_W'(cfg.start);
    lim_w     = CMP_W'(cfg.start) + CMP_W'(cfg.range_val);
    at_full   = (count_r == CNT_W'(MAX_BYTES));
    rv_big    = (17'(cfg.range_val) > 17'(MAX_END_OFFSET));
    rv_m1     = cfg.range_val - 16'd1;
    accept    = go && beat.byte_vld && !at_full;
    take_new  = 1'b0;
    take_ring = 1'b0;
    ring_act  = 1'b0;
    if (cfg.kind == KIND_LENGTH) begin
      take_new = (idx_w >= start_w) && (idx_w < lim_w);
    end else if (!rv_big) begin
      if (cfg.range_val == '0) begin
        take_new = (idx_w >= start_w);
      end else begin
        take_ring = (idx_w >= lim_w);
        ring_act  = 1'b1;
      end
    end
    take_val  = take_ring ? cell_q[0] : beat.data;

    count_upd = accept ? (count_r + CNT_W'(1)) : count_r;
    ovf_upd   = ovf_r | (go && beat.byte_vld && at_full);
    sum_upd   = sum_r;
    xsum_upd  = xsum_r;
    if (accept && (take_new || take_ring)) begin
      sum_upd  = sum_r + take_val;
      xsum_upd = xsum_r ^ take_val;
    end

    fin_count     = count_upd;
    fin_snap.sum  = sum_upd;
    fin_snap.xsum = xsum_upd;
    fin_snap.err  = beat.msg_err | ovf_upd;

    if (go && beat.last) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
      sum_nxt   = '0;
      xsum_nxt  = '0;
    end else begin
      count_nxt = count_upd;
      ovf_nxt   = ovf_upd;
      sum_nxt   = sum_upd;
      xsum_nxt  = xsum_upd;
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic            hit;
    logic [CK_W-1:0] nbr;
    assign hit = (rv_m1 == 16'(k));
    if (k == DEPTH - 1) begin : g_top
      assign nbr = beat.data;
    end else begin : g_mid
      assign nbr = cell_q[k+1];
    end
    smcc_tail_cell u_cell (
      .clk      (clk),
      .shift    (accept && ring_act),
      .load_new (hit),
      .din_new  (beat.data),
      .din_next (nbr),
      .q        (cell_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      sum_r   <= '0;
      xsum_r  <= '0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      sum_r   <= sum_nxt;
      xsum_r  <= xsum_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/smcc_result_stage.sv
// ----------------------------------------------------------------------------
// smcc_result_stage
// Grade the finished message, form the checksum and hold the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module smcc_result_stage import smcc_pkg::*; #(
  parameter int MAX_BYTES      = 65535,
  parameter int MAX_END_OFFSET = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [$clog2(MAX_BYTES+1)-1:0] fin_count,
  input  smcc_snap_t                     fin_snap,
  input  smcc_cfg_t                      cfg,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [OUT_DATA_W-1:0]          out_data,
  output logic                           adv,
  output logic                           hold_vld
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int CMP_W = (CNT_W > CFG_W + 1) ? CNT_W : CFG_W + 1;

  logic                  s3_vld_r, s3_vld_nxt;
  logic [CNT_W-1:0]      cnt_r;
  smcc_snap_t            snap_r;
  logic                  out_vld_r, out_vld_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_free, move, rv_big;
  logic [CMP_W-1:0]      size_w, start_w, lim_w;
  logic [ST_W-1:0]       status;
  logic [USED_W-1:0]     used;
  logic [CK_W-1:0]       ck;

  always_comb begin
    out_free = !out_vld_r || out_ready;
    adv      = !s3_vld_r || out_free;
    move     = s3_vld_r && out_free;

    size_w  = CMP_W'(cnt_r);
    start_w = CMP_W'(cfg.start);
    lim_w   = CMP_W'(cfg.start) + CMP_W'(cfg.range_val);
    rv_big  = (17'(cfg.range_val) > 17'(MAX_END_OFFSET));

    status = ST_OK;
    used   = '0;
    priority if (snap_r.err || (cnt_r == '0)) begin
      status = ST_BAD_HEX;
    end else if (start_w >= size_w) begin
      status = ST_BAD_START;
    end else if (cfg.kind == KIND_LENGTH) begin
      priority if (cfg.range_val == '0) begin
        status = ST_BAD_LEN;
      end else if (lim_w > size_w) begin
        status = ST_EXCEEDS;
      end else begin
        used = cfg.range_val;
      end
    end else begin
      priority if (rv_big || (size_w <= lim_w)) begin
        status = ST_BAD_OFS;
      end else begin
        used = USED_W'(size_w - lim_w);
      end
    end

    ck = '0;
    if (status == ST_OK) begin
      unique case (cfg.mode)
        MODE_TWOS:    ck = CK_W'(0) - snap_r.sum;
        MODE_XOR:     ck = snap_r.xsum;
        MODE_ONES:    ck = ~snap_r.sum;
        MODE_SUM:     ck = snap_r.sum;
        MODE_SUM_ALT: ck = snap_r.sum;
        MODE_MAGIC:   ck = MAGIC_BASE[CK_W-1:0] - snap_r.sum;
        default:      ck = '0;
      endcase
    end

    s3_vld_nxt = load ? 1'b1 : (move ? 1'b0 : s3_vld_r);
    out_vld_nxt  = move ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
    out_data_nxt = move ? {OUT_PAD_W'(0), used, status, ck} : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s3_vld_r  <= s3_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt_r  <= fin_count;
      snap_r <= fin_snap;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;
  assign hold_vld  = s3_vld_r;

endmodule

`default_nettype wire

>>> sv/sysex_multi_mode_checksum_core.sv
// ----------------------------------------------------------------------------
// sysex_multi_mode_checksum_core
// Hex-text SysEx checksum engine with selectable window and checksum mode.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one ASCII character per beat, in_tlast on the final character.
//   out_*  : one result beat per message, issued for the in_tlast beat.
//   cfg_*  : register writes (mode, range kind, start byte, range value),
//            taken at any edge with cfg_we high; write only between messages.
// Throughput: one character per cycle, every character type, while in_tready is high.
// Result path: the last character is taken into the decode register, accumulated
//   into the grading register and then copied into the output register.
// The tail of an offset-from-end window waits in a row of MAX_END_OFFSET
//   byte cells that shift once per packed byte; its length sets the area.
// Reset clears the config registers, message state and every valid flag; the
//   data registers and tail cells keep stale values a new message never reads.
// When out_tready is low the result waits in the output register while
//   characters keep flowing; a final character stalls in_tready only while
//   both the grading register and the output register hold results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sysex_multi_mode_checksum_core_macros.svh"

module sysex_multi_mode_checksum_core import smcc_pkg::*; #(
  parameter int MAX_BYTES      = 65535,
  parameter int MAX_END_OFFSET = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CHAR_W-1:0]     in_tdata,    // [7:0] character
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [6:0] checksum, [9:7] status,
                                             // [25:10] bytes_used, rest zero
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  smcc_cfg_t         cfg_r, cfg_nxt;
  logic              s1_vld, s1_go, s3_adv, s3_vld, snap_load, in_take;
  smcc_beat_t        s1_beat;
  logic [CNT_W-1:0]  fin_count;
  smcc_snap_t        fin_snap;
  logic [CK_W-1:0]   res_ck;
  logic [ST_W-1:0]   res_st;
  logic [USED_W-1:0] res_used;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_MODE:  cfg_nxt.mode      = cfg_wdata[2:0];
        REG_KIND:  cfg_nxt.kind      = cfg_wdata[0];
        REG_START: cfg_nxt.start     = cfg_wdata;
        REG_RANGE: cfg_nxt.range_val = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_TWOS;
      cfg_r.kind      <= KIND_LENGTH;
      cfg_r.start     <= '0;
      cfg_r.range_val <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign s1_go     = s1_vld && (!s1_beat.last || s3_adv);
  assign in_tready = !s1_vld || s1_go;
  assign in_take   = in_tvalid && in_tready;
  assign snap_load = s1_go && s1_beat.last;

  smcc_hex_stage u_hex (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_take),
    .in_char  (in_tdata),
    .in_last  (in_tlast),
    .drain    (s1_go),
    .beat_vld (s1_vld),
    .beat     (s1_beat)
  );

  smcc_window_acc #(
    .MAX_BYTES      (MAX_BYTES),
    .MAX_END_OFFSET (MAX_END_OFFSET)
  ) u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (s1_go),
    .beat      (s1_beat),
    .cfg       (cfg_r),
    .fin_count (fin_count),
    .fin_snap  (fin_snap)
  );

  smcc_result_stage #(
    .MAX_BYTES      (MAX_BYTES),
    .MAX_END_OFFSET (MAX_END_OFFSET)
  ) u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (snap_load),
    .fin_count (fin_count),
    .fin_snap  (fin_snap),
    .cfg       (cfg_r),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .adv       (s3_adv),
    .hold_vld  (s3_vld)
  );

  assign res_ck   = out_tdata[CK_W-1:0];
  assign res_st   = out_tdata[CK_W +: ST_W];
  assign res_used = out_tdata[CK_W + ST_W +: USED_W];

  `SMCC_ASSERT_IMP(a_err_zero, out_tvalid && (res_st != ST_OK), (res_ck == '0) && (res_used == '0))
  `SMCC_ASSERT_IMP(a_stall_only_on_last, !in_tready, s1_vld && s1_beat.last && s3_vld)
  `SMCC_ASSERT_NXT(a_grade_holds, s3_vld && out_tvalid && !out_tready, s3_vld)

endmodule

`default_nettype wire
